### rtl/arithmetic_expression_tokenizer_core_macros.svh
// Assertion macros shared by the verification code of the tokenizer core.
`ifndef ARITHMETIC_EXPRESSION_TOKENIZER_CORE_MACROS_SVH
`define ARITHMETIC_EXPRESSION_TOKENIZER_CORE_MACROS_SVH

// Checked only outside reset.
`define AET_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define AET_CHK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/aet_pkg.sv
// ----------------------------------------------------------------------------
// aet_pkg
// Shared types and constants of the arithmetic expression tokenizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package aet_pkg;

  localparam int POS_BITS_DEF = 16;
  localparam int TOK_W        = 16;
  localparam int KIND_W       = 4;
  localparam int Q_DEPTH      = 4;

  // token kinds
  localparam logic [KIND_W-1:0] TK_END     = 4'd0;
  localparam logic [KIND_W-1:0] TK_ASSIGN  = 4'd1;
  localparam logic [KIND_W-1:0] TK_LPAREN  = 4'd2;
  localparam logic [KIND_W-1:0] TK_RPAREN  = 4'd3;
  localparam logic [KIND_W-1:0] TK_VAR     = 4'd4;
  localparam logic [KIND_W-1:0] TK_ADD     = 4'd5;
  localparam logic [KIND_W-1:0] TK_SUB     = 4'd6;
  localparam logic [KIND_W-1:0] TK_MUL     = 4'd7;
  localparam logic [KIND_W-1:0] TK_DIV     = 4'd8;
  localparam logic [KIND_W-1:0] TK_POW     = 4'd9;
  localparam logic [KIND_W-1:0] TK_LITERAL = 4'd10;
  localparam logic [KIND_W-1:0] TK_IDENT   = 4'd11;
  localparam logic [KIND_W-1:0] TK_ERROR   = 4'd12;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_marker;
  } in_req_t;

  typedef struct packed {
    logic [KIND_W-1:0] token_kind;
    logic [TOK_W-1:0]  token_start;
    logic [TOK_W-1:0]  token_length;
    logic              last_of_run;
  } out_tok_t;

  // up to two tokens handed from the lexer to the result queue per request
  typedef struct packed {
    logic     en0;
    logic     en1;
    out_tok_t tok0;
    out_tok_t tok1;
  } tok_push_t;

endpackage

`default_nettype wire

### rtl/aet_lexer.sv
// ----------------------------------------------------------------------------
// aet_lexer
// Input register, scan state and the per-byte token decision.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aet_lexer #(
  parameter int POSITION_BITS = aet_pkg::POS_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire aet_pkg::in_req_t   in_data,
  input  wire logic               q_room,
  output aet_pkg::tok_push_t      push
);

  localparam int TW = aet_pkg::TOK_W;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_V     = 8'h76;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_R     = 8'h72;

  localparam logic [2:0] KW_NONE = 3'd0;
  localparam logic [2:0] KW_V    = 3'd1;
  localparam logic [2:0] KW_VA   = 3'd2;
  localparam logic [2:0] KW_VAR  = 3'd3;
  localparam logic [2:0] KW_DEAD = 3'd7;

  typedef enum logic [2:0] {
    M_IDLE  = 3'd0,
    M_INT   = 3'd1,
    M_FRAC  = 3'd2,
    M_IDENT = 3'd3,
    M_ERROR = 3'd4
  } mode_t;

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    is_alpha = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    is_space = (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
  endfunction

  function automatic logic [aet_pkg::KIND_W-1:0] op_kind(input logic [7:0] c);
    case (c)
      CH_EQ:    op_kind = aet_pkg::TK_ASSIGN;
      CH_LPAR:  op_kind = aet_pkg::TK_LPAREN;
      CH_RPAR:  op_kind = aet_pkg::TK_RPAREN;
      CH_PLUS:  op_kind = aet_pkg::TK_ADD;
      CH_MINUS: op_kind = aet_pkg::TK_SUB;
      CH_STAR:  op_kind = aet_pkg::TK_MUL;
      CH_SLASH: op_kind = aet_pkg::TK_DIV;
      CH_CARET: op_kind = aet_pkg::TK_POW;
      default:  op_kind = aet_pkg::TK_END;
    endcase
  endfunction

  function automatic logic [2:0] kw_step(input logic [2:0] kw, input logic [7:0] c);
    if (kw == KW_NONE && c == CH_V) kw_step = KW_V;
    else if (kw == KW_V && c == CH_A) kw_step = KW_VA;
    else if (kw == KW_VA && c == CH_R) kw_step = KW_VAR;
    else kw_step = KW_DEAD;
  endfunction

  logic                     in_vld_r;
  aet_pkg::in_req_t         in_q_r;
  mode_t                    mode_r, mode_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [POSITION_BITS-1:0] pst_r, pst_nxt;
  logic [POSITION_BITS-1:0] plen_r, plen_nxt;
  logic [2:0]               kw_r, kw_nxt;

  logic                     adv;
  logic [TW-1:0]            pos_w, pst_w, plen_w;
  logic                     closed, fresh, handle;
  aet_pkg::out_tok_t        pend_tok, fresh_tok;
  logic [7:0]               c;
  logic [aet_pkg::KIND_W-1:0] op;

  assign adv      = in_vld_r && q_room;
  assign in_ready = !in_vld_r || adv;
  assign c        = in_q_r.char_code;
  assign op       = op_kind(c);

  // output fields carry the position counters, cut or zero-extended to the token width
  if (POSITION_BITS >= TW) begin : g_trunc
    assign pos_w  = pos_r[TW-1:0];
    assign pst_w  = pst_r[TW-1:0];
    assign plen_w = plen_r[TW-1:0];
  end else begin : g_ext
    assign pos_w  = {{(TW-POSITION_BITS){1'b0}}, pos_r};
    assign pst_w  = {{(TW-POSITION_BITS){1'b0}}, pst_r};
    assign plen_w = {{(TW-POSITION_BITS){1'b0}}, plen_r};
  end

  always_comb begin
    mode_nxt  = mode_r;
    pos_nxt   = pos_r;
    pst_nxt   = pst_r;
    plen_nxt  = plen_r;
    kw_nxt    = kw_r;
    closed    = 1'b0;
    fresh     = 1'b0;
    handle    = 1'b0;
    fresh_tok = '{token_kind: aet_pkg::TK_END, token_start: pos_w,
                  token_length: TW'(1), last_of_run: 1'b0};

    pend_tok.token_kind   = (mode_r == M_IDENT) ?
                            ((kw_r == KW_VAR) ? aet_pkg::TK_VAR : aet_pkg::TK_IDENT) :
                            aet_pkg::TK_LITERAL;
    pend_tok.token_start  = pst_w;
    pend_tok.token_length = plen_w;
    pend_tok.last_of_run  = 1'b0;

    if (in_q_r.end_marker) begin
      closed = (mode_r == M_INT) || (mode_r == M_FRAC) || (mode_r == M_IDENT);
      fresh  = 1'b1;
      fresh_tok.token_length = '0;
      mode_nxt = M_IDLE;
      pos_nxt  = '0;
      pst_nxt  = '0;
      plen_nxt = '0;
      kw_nxt   = KW_NONE;
    end else begin
      pos_nxt = (pos_r == '1) ? pos_r : pos_r + POSITION_BITS'(1);
      case (mode_r)
        M_ERROR: begin
        end
        M_INT: begin
          if (is_digit(c)) begin
            plen_nxt = (plen_r == '1) ? plen_r : plen_r + POSITION_BITS'(1);
          end else if (c == CH_DOT) begin
            plen_nxt = (plen_r == '1) ? plen_r : plen_r + POSITION_BITS'(1);
            mode_nxt = M_FRAC;
          end else begin
            closed = 1'b1;
            handle = 1'b1;
          end
        end
        M_FRAC: begin
          if (is_digit(c)) begin
            plen_nxt = (plen_r == '1) ? plen_r : plen_r + POSITION_BITS'(1);
          end else begin
            closed = 1'b1;
            handle = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_alpha(c)) begin
            plen_nxt = (plen_r == '1) ? plen_r : plen_r + POSITION_BITS'(1);
            kw_nxt   = kw_step(kw_r, c);
          end else begin
            closed = 1'b1;
            handle = 1'b1;
          end
        end
        default: begin
          handle = 1'b1;
        end
      endcase

      if (handle) begin
        mode_nxt = M_IDLE;
        if (closed) kw_nxt = KW_NONE;
        if (is_space(c)) begin
        end else if (op != aet_pkg::TK_END) begin
          fresh = 1'b1;
          fresh_tok.token_kind = op;
        end else if (is_digit(c)) begin
          mode_nxt = M_INT;
          pst_nxt  = pos_r;
          plen_nxt = POSITION_BITS'(1);
        end else if (is_alpha(c)) begin
          mode_nxt = M_IDENT;
          pst_nxt  = pos_r;
          plen_nxt = POSITION_BITS'(1);
          kw_nxt   = kw_step(KW_NONE, c);
        end else begin
          fresh    = 1'b1;
          fresh_tok.token_kind = aet_pkg::TK_ERROR;
          mode_nxt = M_ERROR;
        end
      end
    end

    // a closed token goes first; the byte's own token follows it
    push.en0  = adv && (closed || fresh);
    push.en1  = adv && closed && fresh;
    push.tok0 = closed ? pend_tok : fresh_tok;
    push.tok0.last_of_run = !(closed && fresh);
    push.tok1 = fresh_tok;
    push.tok1.last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      mode_r   <= M_IDLE;
      pos_r    <= '0;
      pst_r    <= '0;
      plen_r   <= '0;
      kw_r     <= KW_NONE;
    end else begin
      if (in_ready) in_vld_r <= in_valid;
      if (adv) begin
        mode_r <= mode_nxt;
        pos_r  <= pos_nxt;
        pst_r  <= pst_nxt;
        plen_r <= plen_nxt;
        kw_r   <= kw_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) in_q_r <= in_data;
  end

endmodule

`default_nettype wire

### rtl/aet_tokq.sv
// ----------------------------------------------------------------------------
// aet_tokq
// Result queue: takes up to two tokens per cycle, hands out one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aet_tokq (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire aet_pkg::tok_push_t  push,
  output logic                     q_room,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output aet_pkg::out_tok_t        out_data
);

  localparam int DEPTH = aet_pkg::Q_DEPTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  aet_pkg::out_tok_t mem_r [DEPTH];
  logic [AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              pop;
  logic [AW-1:0]     wr_ptr_p1;

  // room for a worst-case pair, judged on the registered count only
  assign q_room    = (cnt_r <= CW'(DEPTH - 2));
  assign out_valid = (cnt_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign wr_ptr_p1 = wr_ptr_r + AW'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + AW'(push.en0) + AW'(push.en1);
    rd_ptr_nxt = rd_ptr_r + AW'(pop);
    cnt_nxt    = cnt_r + CW'(push.en0) + CW'(push.en1) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.en0) mem_r[wr_ptr_r] <= push.tok0;
    if (push.en1) mem_r[wr_ptr_p1] <= push.tok1;
  end

endmodule

`default_nettype wire

### rtl/arithmetic_expression_tokenizer_core.sv
// Timing: an accepted request is held in the input register and decoded there; its
//   tokens enter the result queue when it has room for a pair, a second behind the first.
// Rate: one request per cycle while the queue has room for a pair; a request yielding
//   two tokens gives them in turn to the single output of the four-entry result queue.
// Reset (rst_n low, synchronous): scan state, position counters and queue are cleared.
// ----------------------------------------------------------------------------
// arithmetic_expression_tokenizer_core
// Byte-stream tokenizer for arithmetic expressions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arithmetic_expression_tokenizer_core #(
  parameter int POSITION_BITS = aet_pkg::POS_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire aet_pkg::in_req_t   in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output aet_pkg::out_tok_t       out_data
);

  aet_pkg::tok_push_t push;
  logic               q_room;

  aet_lexer #(
    .POSITION_BITS (POSITION_BITS)
  ) u_lexer (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_room   (q_room),
    .push     (push)
  );

  aet_tokq u_tokq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .q_room    (q_room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### rtl/aet_checker.sv
// ----------------------------------------------------------------------------
// aet_checker
// Port-level checks of the tokenizer core, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "arithmetic_expression_tokenizer_core_macros.svh"

module aet_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire aet_pkg::in_req_t   in_data,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire aet_pkg::out_tok_t  out_data
);

  logic is_single;
  logic is_end_tok;
  logic end_ok;
  logic single_ok;
  logic in_stall;
  logic out_stall;

  assign is_single = (out_data.token_kind == aet_pkg::TK_ASSIGN) ||
                     (out_data.token_kind == aet_pkg::TK_LPAREN) ||
                     (out_data.token_kind == aet_pkg::TK_RPAREN) ||
                     (out_data.token_kind == aet_pkg::TK_ADD) ||
                     (out_data.token_kind == aet_pkg::TK_SUB) ||
                     (out_data.token_kind == aet_pkg::TK_MUL) ||
                     (out_data.token_kind == aet_pkg::TK_DIV) ||
                     (out_data.token_kind == aet_pkg::TK_POW) ||
                     (out_data.token_kind == aet_pkg::TK_ERROR);

  assign is_end_tok = (out_data.token_kind == aet_pkg::TK_END);
  assign end_ok     = (out_data.token_length == '0) && out_data.last_of_run;
  assign single_ok  = (out_data.token_length == aet_pkg::TOK_W'(1)) && out_data.last_of_run;
  assign in_stall   = in_valid && !in_ready;
  assign out_stall  = out_valid && !out_ready;

  `AET_CHK_ALWAYS(a_idle_after_reset, !rst_n |=> !out_valid, "result after reset")
  `AET_CHK(a_in_hold, in_stall |=> in_valid && $stable(in_data), "waiting request changed")
  `AET_CHK(a_hold_stalled, out_stall |=> out_valid && $stable(out_data), "stalled token changed")
  `AET_CHK(a_end_shape, out_valid && is_end_tok |-> end_ok, "bad end token")
  `AET_CHK(a_single_len, out_valid && is_single |-> single_ok, "bad single-byte token")

endmodule

bind arithmetic_expression_tokenizer_core aet_checker u_aet_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
